// ----- src/qn_pkg.sv -----
package qn_pkg;

    // component width default and fixed field widths
    localparam int COMPONENT_BITS_DEF = 32;
    localparam int FIELD_BITS = 32;
    localparam int LANES = 4;
    localparam int TOL_BITS = 41;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 41'd1152921;

    // squared length, root and quotient widths
    localparam int LEN_BITS = 64;
    localparam int ROOT_BITS = 32;
    localparam int MAG_BITS = 32;
    localparam int QUO_BITS = 32;
    localparam int NORM_STEPS = 5;

    typedef enum logic [1:0] {
        KIND_UNIT   = 2'd0,
        KIND_SCALED = 2'd1,
        KIND_ZERO   = 2'd2
    } kind_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] w_in;
        logic signed [FIELD_BITS-1:0] x_in;
        logic signed [FIELD_BITS-1:0] y_in;
        logic signed [FIELD_BITS-1:0] z_in;
        logic                         zero_small;
    } quat_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] w_out;
        logic signed [FIELD_BITS-1:0] x_out;
        logic signed [FIELD_BITS-1:0] y_out;
        logic signed [FIELD_BITS-1:0] z_out;
        logic [1:0]                   case_taken;
    } norm_t;

    // per-item data that rides along the chains
    typedef struct packed {
        logic [LANES-1:0]                 neg;
        kind_t                            kind;
        logic                             carry;
        logic                             zero_small;
        logic [LANES-1:0][FIELD_BITS-1:0] orig;
    } side_t;

    typedef struct packed {
        logic                           valid;
        logic [LEN_BITS-1:0]            m;
        logic [LANES-1:0][MAG_BITS-1:0] mag;
        side_t                          side;
    } norm_bus_t;

    typedef struct packed {
        logic                           valid;
        logic [LEN_BITS-1:0]            m;
        logic [ROOT_BITS:0]             rem;
        logic [ROOT_BITS-1:0]           root;
        logic [LANES-1:0][MAG_BITS-1:0] mag;
        side_t                          side;
    } sqrt_bus_t;

    typedef struct packed {
        logic                            valid;
        logic [ROOT_BITS:0]              divisor;
        logic [LANES-1:0][ROOT_BITS:0]   prem;
        logic [LANES-1:0][QUO_BITS-1:0]  nlow;
        logic [LANES-1:0][QUO_BITS-1:0]  quo;
        side_t                           side;
    } div_bus_t;

endpackage

// ----- src/qn_norm_cell.sv -----
module qn_norm_cell #(
    parameter int SHIFT = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  qn_pkg::norm_bus_t din,
    output qn_pkg::norm_bus_t dout
);

    qn_pkg::norm_bus_t data_next;
    qn_pkg::norm_bus_t data_reg;
    logic              valid_reg;

    // shift the length up when no carry is set and its top bits are clear, magnitudes by half as much
    always_comb
    begin
        data_next = din;
        if (!din.side.carry && (din.m[qn_pkg::LEN_BITS-1 -: SHIFT] == '0))
        begin
            data_next.m = din.m << SHIFT;
            for (int i = 0; i < qn_pkg::LANES; i++)
            begin
                data_next.mag[i] = din.mag[i] << (SHIFT / 2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

// ----- src/qn_sqrt_cell.sv -----
module qn_sqrt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  qn_pkg::sqrt_bus_t din,
    output qn_pkg::sqrt_bus_t dout
);

    qn_pkg::sqrt_bus_t            data_next;
    qn_pkg::sqrt_bus_t            data_reg;
    logic                         valid_reg;
    logic [qn_pkg::ROOT_BITS+2:0] trial_rem;
    logic [qn_pkg::ROOT_BITS+2:0] trial_sub;
    logic [qn_pkg::ROOT_BITS+2:0] trial_dif;

    // one root bit: bring down two radicand bits and try 4q+1
    always_comb
    begin
        data_next = din;
        trial_rem = {din.rem, din.m[qn_pkg::LEN_BITS-1 -: 2]};
        trial_sub = {1'b0, din.root, 2'b01};
        trial_dif = trial_rem - trial_sub;
        data_next.m = din.m << 2;
        if (trial_rem >= trial_sub)
        begin
            data_next.rem  = trial_dif[qn_pkg::ROOT_BITS:0];
            data_next.root = {din.root[qn_pkg::ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = trial_rem[qn_pkg::ROOT_BITS:0];
            data_next.root = {din.root[qn_pkg::ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

// ----- src/qn_div_cell.sv -----
module qn_div_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  qn_pkg::div_bus_t din,
    output qn_pkg::div_bus_t dout
);

    qn_pkg::div_bus_t data_next;
    qn_pkg::div_bus_t data_reg;
    logic             valid_reg;
    logic [qn_pkg::LANES-1:0][qn_pkg::ROOT_BITS+1:0] trial;
    logic [qn_pkg::LANES-1:0][qn_pkg::ROOT_BITS+1:0] dif;
    logic [qn_pkg::LANES-1:0]                        ge;

    // one quotient bit in each lane, shared divisor
    always_comb
    begin
        data_next = din;
        for (int i = 0; i < qn_pkg::LANES; i++)
        begin
            trial[i] = {din.prem[i], din.nlow[i][qn_pkg::QUO_BITS-1]};
            dif[i]   = trial[i] - {1'b0, din.divisor};
            ge[i]    = trial[i] >= {1'b0, din.divisor};
            data_next.prem[i] = ge[i] ? dif[i][qn_pkg::ROOT_BITS:0]
                                      : trial[i][qn_pkg::ROOT_BITS:0];
            data_next.nlow[i] = din.nlow[i] << 1;
            data_next.quo[i]  = {din.quo[i][qn_pkg::QUO_BITS-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

// ----- src/quaternion_normalize.sv -----
// channel   direction  handshake               payload
// quat      in         quat_valid/quat_stall   qn_pkg::quat_t
// norm      out        norm_valid/norm_stall   qn_pkg::norm_t
// cfg       in         cfg_valid/cfg_ready     fuzz_tolerance (41 bits)
//
// one item per cycle sustained while quat_stall is low
// the pipeline includes the 32-cell square root chain and the 32-cell divider chain
// rst_n clears all valid bits and loads fuzz_tolerance with its default
// a skid register behind the output register absorbs one item under norm_stall;
// quat_stall is the registered skid-full flag and holds the whole chain
module quaternion_normalize #(
    parameter int COMPONENT_BITS = qn_pkg::COMPONENT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          quat_valid,
    output logic                          quat_stall,
    input  qn_pkg::quat_t                 quat,
    output logic                          norm_valid,
    input  logic                          norm_stall,
    output qn_pkg::norm_t                 norm,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qn_pkg::TOL_BITS-1:0]   cfg_data
);

    localparam int FRAC_BITS = COMPONENT_BITS - 2;
    localparam int FB = qn_pkg::FIELD_BITS;
    localparam int LB = qn_pkg::LEN_BITS;
    localparam int RB = qn_pkg::ROOT_BITS;
    localparam int NL = qn_pkg::LANES;
    localparam logic [FB:0] POS_MAX = ((FB+1)'(1) << (COMPONENT_BITS - 1)) - (FB+1)'(1);
    localparam logic [FB:0] NEG_MAX = (FB+1)'(1) << (COMPONENT_BITS - 1);

    logic                         en;
    logic [qn_pkg::TOL_BITS-1:0]  tol_reg;

    logic [NL-1:0][FB-1:0]              raw;
    logic [NL-1:0][FB-1:0]              a_orig;
    logic [NL-1:0]                      a_neg;
    logic [NL-1:0][qn_pkg::MAG_BITS-1:0] a_mag;

    logic                                a_valid_reg;
    qn_pkg::side_t                       a_side_reg;
    logic [NL-1:0][qn_pkg::MAG_BITS-1:0] a_mag_reg;
    logic                                b_valid_reg;
    qn_pkg::side_t                       b_side_reg;
    logic [NL-1:0][qn_pkg::MAG_BITS-1:0] b_mag_reg;
    logic [NL-1:0][LB-1:0]               b_sq_reg;
    logic                                c_valid_reg;
    qn_pkg::side_t                       c_side_reg;
    logic [NL-1:0][qn_pkg::MAG_BITS-1:0] c_mag_reg;
    logic [LB:0]                         c_acc_reg;

    logic [LB-1:0]      d_len;
    logic [LB-1:0]      d_diff;
    logic [LB-1:0]      d_tol;
    qn_pkg::kind_t      d_kind;
    logic               d_valid_reg;
    qn_pkg::norm_bus_t  d_bus_next;
    qn_pkg::norm_bus_t  d_bus_reg;

    qn_pkg::norm_bus_t nb [qn_pkg::NORM_STEPS+1];
    qn_pkg::sqrt_bus_t sb [RB+1];
    qn_pkg::div_bus_t  db [qn_pkg::QUO_BITS+1];

    logic               e_valid_reg;
    qn_pkg::div_bus_t   e_bus_next;
    qn_pkg::div_bus_t   e_bus_reg;
    logic [NL-1:0][LB-1:0] e_num;

    qn_pkg::div_bus_t      last;
    logic                  push;
    logic [NL-1:0][FB:0]   f_clamp;
    logic [NL-1:0][FB:0]   f_negv;
    logic [NL-1:0][FB-1:0] f_res;
    qn_pkg::norm_t         f_item;

    logic           out_valid_reg;
    qn_pkg::norm_t  out_reg;
    logic           skid_valid_reg;
    qn_pkg::norm_t  skid_reg;
    logic           out_free;

    assign en         = !skid_valid_reg;
    assign quat_stall = skid_valid_reg;
    assign cfg_ready  = 1'b1;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= qn_pkg::TOL_RESET;
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_data;
        end
    end

    // split components into sign and magnitude
    assign raw[0] = quat.w_in;
    assign raw[1] = quat.x_in;
    assign raw[2] = quat.y_in;
    assign raw[3] = quat.z_in;

    for (genvar i = 0; i < NL; i++)
    begin : g_split
        logic signed [COMPONENT_BITS-1:0] low;
        logic [FB:0] wide;
        logic [FB:0] negw;
        assign low       = raw[i][COMPONENT_BITS-1:0];
        assign a_orig[i] = FB'(low);
        assign a_neg[i]  = low[COMPONENT_BITS-1];
        assign wide      = {a_orig[i][FB-1], a_orig[i]};
        assign negw      = (FB+1)'(0) - wide;
        assign a_mag[i]  = a_neg[i] ? negw[FB-1:0] : wide[FB-1:0];
    end

    // front stages: magnitudes, squares, sum, and the case and divisor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= quat_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= sb[RB].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg.neg        <= a_neg;
            a_side_reg.kind       <= qn_pkg::KIND_UNIT;
            a_side_reg.carry      <= 1'b0;
            a_side_reg.zero_small <= quat.zero_small;
            a_side_reg.orig       <= a_orig;
            a_mag_reg             <= a_mag;
            b_side_reg            <= a_side_reg;
            b_mag_reg             <= a_mag_reg;
            for (int i = 0; i < NL; i++)
            begin
                b_sq_reg[i] <= LB'(a_mag_reg[i]) * LB'(a_mag_reg[i]);
            end
            c_side_reg <= b_side_reg;
            c_mag_reg  <= b_mag_reg;
            c_acc_reg  <= (LB+1)'(b_sq_reg[0]) + (LB+1)'(b_sq_reg[1])
                        + (LB+1)'(b_sq_reg[2]) + (LB+1)'(b_sq_reg[3]);
            d_bus_reg  <= d_bus_next;
            e_bus_reg  <= e_bus_next;
        end
    end

    // near-one and near-zero tests
    always_comb
    begin
        d_len  = c_acc_reg[LB-1:0];
        d_tol  = LB'(tol_reg);
        d_diff = (d_len >= (LB'(1) << (2 * FRAC_BITS))) ? d_len - (LB'(1) << (2 * FRAC_BITS))
                                                        : (LB'(1) << (2 * FRAC_BITS)) - d_len;
        if (!c_acc_reg[LB] && d_diff <= d_tol)
        begin
            d_kind = qn_pkg::KIND_UNIT;
        end
        else if (!c_acc_reg[LB] && d_len <= d_tol)
        begin
            d_kind = qn_pkg::KIND_ZERO;
        end
        else
        begin
            d_kind = qn_pkg::KIND_SCALED;
        end
        d_bus_next            = '0;
        d_bus_next.m          = d_len;
        d_bus_next.mag        = c_mag_reg;
        d_bus_next.side       = c_side_reg;
        d_bus_next.side.kind  = d_kind;
        d_bus_next.side.carry = c_acc_reg[LB];
    end

    always_comb
    begin
        nb[0]       = d_bus_reg;
        nb[0].valid = d_valid_reg;
    end

    // normalizing shift chain
    for (genvar j = 0; j < qn_pkg::NORM_STEPS; j++)
    begin : g_norm
        qn_norm_cell #(
            .SHIFT ((LB / 2) >> j)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (nb[j]),
            .dout  (nb[j+1])
        );
    end

    always_comb
    begin
        sb[0].valid = nb[qn_pkg::NORM_STEPS].valid;
        sb[0].m     = nb[qn_pkg::NORM_STEPS].m;
        sb[0].rem   = '0;
        sb[0].root  = '0;
        sb[0].mag   = nb[qn_pkg::NORM_STEPS].mag;
        sb[0].side  = nb[qn_pkg::NORM_STEPS].side;
    end

    // square root chain, one root bit per cell
    for (genvar j = 0; j < RB; j++)
    begin : g_sqrt
        qn_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (sb[j]),
            .dout  (sb[j+1])
        );
    end

    // divisor and rounded numerators
    always_comb
    begin
        e_bus_next         = '0;
        e_bus_next.side    = sb[RB].side;
        e_bus_next.divisor = sb[RB].side.carry ? ((RB+1)'(1) << RB) : {1'b0, sb[RB].root};
        for (int i = 0; i < NL; i++)
        begin
            e_num[i] = (LB'(sb[RB].mag[i]) << FRAC_BITS) + LB'(e_bus_next.divisor >> 1);
            e_bus_next.prem[i] = {1'b0, e_num[i][LB-1 -: RB]};
            e_bus_next.nlow[i] = e_num[i][qn_pkg::QUO_BITS-1:0];
        end
    end

    always_comb
    begin
        db[0]       = e_bus_reg;
        db[0].valid = e_valid_reg;
    end

    // divider chain, one quotient bit per cell in all lanes
    for (genvar j = 0; j < qn_pkg::QUO_BITS; j++)
    begin : g_div
        qn_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (db[j]),
            .dout  (db[j+1])
        );
    end

    // saturate, restore sign, pick by case
    assign last = db[qn_pkg::QUO_BITS];
    assign push = en && last.valid;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            if (last.side.neg[i])
            begin
                f_clamp[i] = ({1'b0, last.quo[i]} > NEG_MAX) ? NEG_MAX : {1'b0, last.quo[i]};
            end
            else
            begin
                f_clamp[i] = ({1'b0, last.quo[i]} > POS_MAX) ? POS_MAX : {1'b0, last.quo[i]};
            end
            f_negv[i] = (FB+1)'(0) - f_clamp[i];
            case (last.side.kind)
                qn_pkg::KIND_UNIT:
                    f_res[i] = last.side.orig[i];
                qn_pkg::KIND_ZERO:
                    f_res[i] = last.side.zero_small ? '0 : last.side.orig[i];
                default:
                    f_res[i] = last.side.neg[i] ? f_negv[i][FB-1:0] : f_clamp[i][FB-1:0];
            endcase
        end
        f_item.w_out      = f_res[0];
        f_item.x_out      = f_res[1];
        f_item.y_out      = f_res[2];
        f_item.z_out      = f_res[3];
        f_item.case_taken = last.side.kind;
    end

    // output register with skid
    assign out_free = !out_valid_reg || !norm_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : f_item;
        end
        else if (push)
        begin
            skid_reg <= f_item;
        end
    end

    assign norm_valid = out_valid_reg;
    assign norm       = out_reg;

endmodule

// ----- dv/tb_quaternion_normalize.sv -----
`timescale 1ns / 1ps

module tb_quaternion_normalize;

    localparam int LATENCY = 75;
    localparam int CYCLE_LIMIT = 1000000;

    logic clk;
    logic rst_n;
    logic quat_valid;
    logic quat_stall;
    qn_pkg::quat_t quat;
    logic norm_valid;
    logic norm_stall;
    qn_pkg::norm_t norm;
    logic cfg_valid;
    logic cfg_ready;
    logic [qn_pkg::TOL_BITS-1:0] cfg_data;

    quaternion_normalize uut (
        .clk(clk),
        .rst_n(rst_n),
        .quat_valid(quat_valid),
        .quat_stall(quat_stall),
        .quat(quat),
        .norm_valid(norm_valid),
        .norm_stall(norm_stall),
        .norm(norm),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // predictor copy of the tolerance register
    logic [qn_pkg::TOL_BITS-1:0] tolerance;
    qn_pkg::norm_t expected_norms[$];
    int error_count;
    int result_count;
    int cycle_count;
    int kind_seen[3];
    bit sink_hold;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("tb_quaternion_normalize NOT OK");
            $finish;
        end
    end

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem = v;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] saturate_signed(bit neg, logic [63:0] mag);
        if (neg)
        begin
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            return 32'(64'd0 - mag);
        end
        if (mag > 64'h7fff_ffff)
            mag = 64'h7fff_ffff;
        return mag[31:0];
    endfunction

    // squared length, case selection and scaling
    function automatic qn_pkg::norm_t normalize_quat(qn_pkg::quat_t q);
        logic [31:0] comp[4];
        bit neg[4];
        logic [63:0] mag[4];
        logic [64:0] len;
        logic [63:0] acc;
        logic [63:0] unit_len;
        logic [63:0] diff;
        logic [63:0] m;
        logic [63:0] s;
        logic [127:0] num;
        logic [31:0] res[4];
        bit carry;
        int k;
        qn_pkg::kind_t kind;
        qn_pkg::norm_t r;
        comp[0] = q.w_in;
        comp[1] = q.x_in;
        comp[2] = q.y_in;
        comp[3] = q.z_in;
        len = '0;
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = comp[i][31];
            mag[i] = neg[i] ? 64'h1_0000_0000 - comp[i] : {32'd0, comp[i]};
            len = len + 65'(mag[i] * mag[i]);
        end
        carry = len[64];
        acc = len[63:0];
        unit_len = 64'd1 << 60;
        diff = (acc >= unit_len) ? acc - unit_len : unit_len - acc;
        if (!carry && diff <= tolerance)
        begin
            kind = qn_pkg::KIND_UNIT;
            for (int i = 0; i < 4; i++)
                res[i] = saturate_signed(neg[i], mag[i]);
        end
        else if (!carry && acc <= tolerance)
        begin
            kind = qn_pkg::KIND_ZERO;
            for (int i = 0; i < 4; i++)
                res[i] = q.zero_small ? 32'd0 : saturate_signed(neg[i], mag[i]);
        end
        else
        begin
            kind = qn_pkg::KIND_SCALED;
            k = 0;
            if (carry)
                s = 64'd1 << 32;
            else
            begin
                m = acc;
                while (m[63:62] == 2'b00)
                begin
                    m = m << 2;
                    k++;
                end
                s = root_floor(m);
            end
            for (int i = 0; i < 4; i++)
            begin
                num = (128'(mag[i]) << (30 + k)) & 128'hffff_ffff_ffff_ffff;
                num = (num + (s >> 1)) & 128'hffff_ffff_ffff_ffff;
                res[i] = saturate_signed(neg[i], 64'(num / s));
            end
        end
        r.w_out = res[0];
        r.x_out = res[1];
        r.y_out = res[2];
        r.z_out = res[3];
        r.case_taken = kind;
        return r;
    endfunction

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // send one item, record its expected result; valid stays up for the next item
    task automatic send_quat(qn_pkg::quat_t q, bit allow_gap);
        int gap;
        gap = allow_gap ? short_or_long_gap() : 0;
        if (gap != 0)
        begin
            quat_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        quat_valid <= 1'b1;
        quat <= q;
        @(posedge clk);
        while (quat_stall)
            @(posedge clk);
        expected_norms.push_back(normalize_quat(q));
        @(negedge clk);
    endtask

    task automatic drain_results();
        quat_valid <= 1'b0;
        while (expected_norms.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_tolerance(logic [qn_pkg::TOL_BITS-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tolerance = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic qn_pkg::quat_t make_quat(int w, int x, int y, int z, bit zs);
        qn_pkg::quat_t q;
        q.w_in = w;
        q.x_in = x;
        q.y_in = y;
        q.z_in = z;
        q.zero_small = zs;
        return q;
    endfunction

    function automatic logic [31:0] random_component();
        case ($urandom_range(0, 5))
            0: return 32'sh4000_0000 >>> $urandom_range(0, 31);
            1: return $urandom_range(0, 8) - 4;
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // near-unit quaternion: one large component with small jitter
    function automatic qn_pkg::quat_t near_unit_quat();
        qn_pkg::quat_t q;
        q = make_quat($urandom_range(0, 7) - 3, $urandom_range(0, 7) - 3,
            $urandom_range(0, 7) - 3, $urandom_range(0, 7) - 3, $urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: q.w_in = $urandom_range(0, 1) ? 32'sh4000_0000 : -32'sh4000_0000;
            1: q.x_in = $urandom_range(0, 1) ? 32'sh4000_0000 : -32'sh4000_0000;
            2: q.y_in = 32'sh4000_0000 + $urandom_range(0, 4) - 2;
            default: q.z_in = -32'sh4000_0000 + $urandom_range(0, 4) - 2;
        endcase
        return q;
    endfunction

    function automatic qn_pkg::quat_t random_quat();
        case ($urandom_range(0, 9))
            0, 1: return near_unit_quat();
            2: return make_quat($urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10,
                $urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10, $urandom_range(0, 1));
            default: return make_quat(random_component(), random_component(),
                random_component(), random_component(), $urandom_range(0, 1));
        endcase
    endfunction

    // receiver stall pattern, with an optional forced hold
    initial
    begin
        int gap;
        norm_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold)
                norm_stall <= 1'b1;
            else
            begin
                gap = short_or_long_gap();
                if (gap == 0 || $urandom_range(0, 3) == 0)
                    norm_stall <= 1'b0;
                else
                begin
                    norm_stall <= 1'b1;
                    repeat (gap) @(negedge clk);
                    norm_stall <= 1'b0;
                end
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        qn_pkg::norm_t exp_norm;
        if (rst_n && norm_valid && !norm_stall)
        begin
            result_count <= result_count + 1;
            if (expected_norms.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, norm);
                error_count++;
            end
            else
            begin
                exp_norm = expected_norms.pop_front();
                if (norm.case_taken < 3)
                    kind_seen[norm.case_taken]++;
                if (norm.w_out !== exp_norm.w_out)
                    $display("%0t: w_out expected %h actual %h", $time,
                        exp_norm.w_out, norm.w_out);
                if (norm.x_out !== exp_norm.x_out)
                    $display("%0t: x_out expected %h actual %h", $time,
                        exp_norm.x_out, norm.x_out);
                if (norm.y_out !== exp_norm.y_out)
                    $display("%0t: y_out expected %h actual %h", $time,
                        exp_norm.y_out, norm.y_out);
                if (norm.z_out !== exp_norm.z_out)
                    $display("%0t: z_out expected %h actual %h", $time,
                        exp_norm.z_out, norm.z_out);
                if (norm.case_taken !== exp_norm.case_taken)
                    $display("%0t: case_taken expected %0d actual %0d", $time,
                        exp_norm.case_taken, norm.case_taken);
                if (norm !== exp_norm)
                    error_count++;
            end
        end
    end

    // extremes, every case and exact zero length
    task automatic test_directed();
        bit zs;
        for (int i = 0; i < 2; i++)
        begin
            zs = i;
            send_quat(make_quat(32'sh4000_0000, 0, 0, 0, zs), 1);
            send_quat(make_quat(0, -32'sh4000_0000, 0, 0, zs), 1);
            send_quat(make_quat(0, 0, 0, 0, zs), 1);
            send_quat(make_quat(1, -1, 1, -1, zs), 1);
            send_quat(make_quat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, zs), 1);
            send_quat(make_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, zs), 1);
            send_quat(make_quat(32'h2000_0000, -32'sh2000_0000, 32'h2000_0000,
                32'h2000_0000, zs), 1);
            send_quat(make_quat(32'h8000_0000, 0, 0, 0, zs), 1);
            send_quat(make_quat(1000, 0, -7, 3, zs), 1);
            send_quat(make_quat(32'h1234_5678, -32'sh0fed_cba9, 32'h0011_2233, 5, zs), 1);
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_quat(random_quat(), 1);
    endtask

    task automatic test_tolerance_sweep();
        logic [qn_pkg::TOL_BITS-1:0] settings[5];
        settings[0] = '0;
        settings[1] = {qn_pkg::TOL_BITS{1'b1}};
        settings[2] = 41'h100_0000_0000;
        settings[3] = 41'd1 << $urandom_range(10, 36);
        settings[4] = qn_pkg::TOL_RESET;
        foreach (settings[s])
        begin
            write_tolerance(settings[s]);
            send_quat(make_quat(0, 0, 0, 0, 1), 1);
            send_quat(make_quat(32'sh4000_0000, 3, 0, 0, 0), 1);
            send_quat(make_quat(32'h0000_8000, 0, 0, 0, 1), 1);
            test_random(200);
        end
    endtask

    // long receiver hold while items keep arriving, then a pause until drained and more items
    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            repeat (200) @(negedge clk);
            for (int i = 0; i < 120; i++)
                send_quat(random_quat(), 0);
        join_any
        sink_hold = 1'b0;
        wait fork;
        drain_results();
        for (int i = 0; i < 100; i++)
            send_quat(random_quat(), 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        quat_valid = 1'b0;
        quat = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        sink_hold = 1'b0;
        error_count = 0;
        result_count = 0;
        cycle_count = 0;
        tolerance = qn_pkg::TOL_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(200);
        test_backpressure();
        test_tolerance_sweep();
        drain_results();
        if (expected_norms.size() != 0)
            error_count++;
        $display("checked %0d normalized quaternions: %0d unit, %0d scaled, %0d near zero",
            result_count, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("tolerance swept from zero to its largest setting, with long output back-pressure");
        if (error_count == 0)
            $display("tb_quaternion_normalize OK");
        else
            $display("tb_quaternion_normalize NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
src/qn_pkg.sv
src/qn_norm_cell.sv
src/qn_sqrt_cell.sv
src/qn_div_cell.sv
src/quaternion_normalize.sv
dv/tb_quaternion_normalize.sv
